>>> design/rss_pkg.sv
// Shared types and constants for the rotor substitution stepper.
// No dependencies; rss_map and the top level refer to this package by scoped names.
package rss_pkg;

  localparam int LetterCount = 26;
  localparam int LetterW     = 5;

  typedef logic [LetterW-1:0] letter_t;

  // Entry i holds the wiring target of letter i.
  typedef logic [LetterCount-1:0][LetterW-1:0] wiring_t;

  typedef enum logic [1:0] {
    OpForward  = 2'd0,
    OpBackward = 2'd1,
    OpRotate   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CfgWiringLow  = 2'd0,
    CfgWiringMid  = 2'd1,
    CfgWiringHigh = 2'd2,
    CfgNotchMask  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    letter_t mapped_letter;
    logic    at_notch;
  } rsp_t;

endpackage

>>> design/rss_req_if.sv
// Request channel of the rotor stepper: valid/ready handshake with operation and letter.
// Depends on nothing.
interface rss_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [4:0] letter;

  modport source (output valid, output operation, output letter, input ready);
  modport sink (input valid, input operation, input letter, output ready);
endinterface

>>> design/rss_rsp_if.sv
// Response channel of the rotor stepper: valid/ready handshake with mapped letter and notch flag.
// Depends on nothing.
interface rss_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] mapped_letter;
  logic       at_notch;

  modport source (output valid, output mapped_letter, output at_notch, input ready);
  modport sink (input valid, input mapped_letter, input at_notch, output ready);
endinterface

>>> design/rss_map.sv
// Letter substitution datapath of one rotor: offset add, wiring select, inverse search.
// Depends on rss_pkg.
module rss_map (
  input  logic [1:0]       op_i,
  input  rss_pkg::letter_t letter_i,
  input  rss_pkg::letter_t offset_i,
  input  rss_pkg::wiring_t wiring_i,
  output rss_pkg::letter_t letter_o
);

  logic [5:0]       sum;
  rss_pkg::letter_t rel;
  rss_pkg::letter_t entry;
  rss_pkg::letter_t fwd;
  rss_pkg::letter_t inv;
  rss_pkg::letter_t pre;
  rss_pkg::letter_t sub;

  assign sum   = {1'b0, letter_i} + {1'b0, offset_i};

  always_comb begin
    if (sum >= 6'(2 * rss_pkg::LetterCount)) begin
      rel = 5'(sum - 6'(2 * rss_pkg::LetterCount));
    end else if (sum >= 6'(rss_pkg::LetterCount)) begin
      rel = 5'(sum - 6'(rss_pkg::LetterCount));
    end else begin
      rel = 5'(sum);
    end
  end

  assign entry = wiring_i[rel];
  assign fwd   = (entry >= 5'(rss_pkg::LetterCount)) ? 5'(entry - 5'(rss_pkg::LetterCount))
                                                     : entry;

  // lowest matching index wins, index 0 when nothing matches
  always_comb begin
    inv = '0;
    for (int j = rss_pkg::LetterCount - 1; j >= 0; j--) begin
      if (wiring_i[j] == rel) begin
        inv = 5'(j);
      end
    end
  end

  assign pre = (op_i == rss_pkg::OpBackward) ? inv : fwd;

  always_comb begin
    if (pre >= offset_i) begin
      sub = pre - offset_i;
    end else begin
      sub = 5'(6'(pre) + 6'(rss_pkg::LetterCount) - 6'(offset_i));
    end
  end

  always_comb begin
    case (op_i)
      rss_pkg::OpForward:  letter_o = sub;
      rss_pkg::OpBackward: letter_o = sub;
      default:             letter_o = letter_i;
    endcase
  end

endmodule

>>> design/rotor_substitution_stepper.sv
// Top level of the rotor substitution stepper: configuration registers, rotor offset, output skid.
// Depends on rss_pkg, rss_req_if, rss_rsp_if and rss_map.

// One request yields one response. The map is combinational from the request port and the rotor
// offset register, so a request is taken every cycle while ready is high. The response goes to the
// result register, or to the skid register while the result register holds an unpopped response.
// The two-entry output stage accepts one more request after the response side stalls; ready drops
// only when both entries hold a response. A rotate request advances the offset at the accepting
// edge, so the next request, even in the following cycle, sees the new offset. Configuration
// writes take effect at the write edge and are to be made while the block is idle.
module rotor_substitution_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [59:0] cfg_wdata_i,
  rss_req_if.sink     req_i,
  rss_rsp_if.source   rsp_o
);

  logic [59:0]      wiring_low_q;
  logic [59:0]      wiring_mid_q;
  logic [9:0]       wiring_high_q;
  logic [25:0]      notch_mask_q;
  rss_pkg::wiring_t wiring;

  rss_pkg::letter_t offset_q;
  rss_pkg::letter_t offset_d;
  rss_pkg::letter_t mapped;

  logic             accept;
  logic             pop;
  rss_pkg::rsp_t    rsp_new;
  rss_pkg::rsp_t    out_q;
  rss_pkg::rsp_t    skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;

  assign wiring = {wiring_high_q, wiring_mid_q, wiring_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiring_low_q  <= '0;
      wiring_mid_q  <= '0;
      wiring_high_q <= '0;
      notch_mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rss_pkg::cfg_reg_e'(cfg_idx_i))
        rss_pkg::CfgWiringLow:  wiring_low_q  <= cfg_wdata_i;
        rss_pkg::CfgWiringMid:  wiring_mid_q  <= cfg_wdata_i;
        rss_pkg::CfgWiringHigh: wiring_high_q <= cfg_wdata_i[9:0];
        rss_pkg::CfgNotchMask:  notch_mask_q  <= cfg_wdata_i[25:0];
        default: ;
      endcase
    end
  end

  rss_map u_map (
    .op_i     (req_i.operation),
    .letter_i (req_i.letter),
    .offset_i (offset_q),
    .wiring_i (wiring),
    .letter_o (mapped)
  );

  assign accept = req_i.valid && req_i.ready;
  assign pop    = out_valid_q && rsp_o.ready;

  always_comb begin
    offset_d = offset_q;
    if (req_i.operation == rss_pkg::OpRotate) begin
      offset_d = (offset_q == 5'(rss_pkg::LetterCount - 1)) ? '0 : offset_q + 5'd1;
    end
  end

  assign rsp_new.mapped_letter = mapped;
  assign rsp_new.at_notch      = notch_mask_q[offset_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (accept) begin
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= rsp_new;
      end
    end else if (accept) begin
      skid_q <= rsp_new;
    end
  end

  assign req_i.ready         = !skid_valid_q;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.mapped_letter = out_q.mapped_letter;
  assign rsp_o.at_notch      = out_q.at_notch;

endmodule
